[design/sta_pkg.sv]
// Shared types and codes for the slot table allocator.
package sta_pkg;

    localparam logic [2:0] ACT_INS_AUTO = 3'd0;
    localparam logic [2:0] ACT_INS_AT   = 3'd1;
    localparam logic [2:0] ACT_REMOVE   = 3'd2;
    localparam logic [2:0] ACT_READ     = 3'd3;
    localparam logic [2:0] ACT_FIND     = 3'd4;
    localparam logic [2:0] ACT_CLEAR    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  slot;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot_out;
        logic [31:0] read_value;
        logic [8:0]  used_count;
    } out_item_t;

endpackage

[design/sta_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module sta_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/sta_engine.sv]
// Request sequencer that reads, modifies and writes back the slot memory.
module sta_engine #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  sta_pkg::in_item_t req_item,
    output logic              res_valid,
    input  logic              res_ready,
    output sta_pkg::out_item_t res_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = DATA_WIDTH + 1;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [16:0] CAP_IDX = 17'(CAPACITY);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_WIPE,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]         hint_reg, hint_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [2:0]            status_reg, status_next;
    logic [7:0]            slot_out_reg, slot_out_next;
    logic [31:0]           rdval_reg, rdval_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [MW-1:0]         ram_rdata;
    logic                  rd_valid;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  in_range;
    logic                  hit;

    sta_ram #(
        .WIDTH(MW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_valid  = ram_rdata[DATA_WIDTH];
    assign rd_data   = ram_rdata[DATA_WIDTH-1:0];
    assign in_range  = 17'(req_item.slot) < CAP_IDX;
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign hit = (op_reg == sta_pkg::ACT_FIND) ? (rd_valid && rd_data == val_reg) : !rd_valid;

    assign res_item = '{
        status:     status_reg,
        slot_out:   slot_out_reg,
        read_value: rdval_reg,
        used_count: 9'(count_reg)
    };

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        val_next      = val_reg;
        hint_next     = hint_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        slot_out_next = slot_out_reg;
        rdval_next    = rdval_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '0;
        ram_raddr     = addr_reg + AW'(1);

        unique case (state_reg)
            S_INIT: begin
                ram_we = 1'b1;
                if (addr_reg == LAST) begin
                    state_next = S_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_IDLE: begin
                ram_raddr = AW'(req_item.slot);
                if (req_valid) begin
                    op_next       = req_item.action;
                    val_next      = DATA_WIDTH'(req_item.value);
                    addr_next     = AW'(req_item.slot);
                    status_next   = sta_pkg::ST_OK;
                    slot_out_next = '0;
                    rdval_next    = '0;
                    unique case (req_item.action) inside
                        sta_pkg::ACT_INS_AUTO: begin
                            if (hint_reg == CAP_C) begin
                                status_next = sta_pkg::ST_FULL;
                                state_next  = S_FINISH;
                            end else begin
                                ram_raddr  = AW'(hint_reg);
                                addr_next  = AW'(hint_reg);
                                state_next = S_SCAN;
                            end
                        end
                        sta_pkg::ACT_FIND: begin
                            ram_raddr  = '0;
                            addr_next  = '0;
                            state_next = S_SCAN;
                        end
                        sta_pkg::ACT_INS_AT, sta_pkg::ACT_REMOVE, sta_pkg::ACT_READ: begin
                            if (in_range) begin
                                state_next = S_LOOK;
                            end else begin
                                status_next = sta_pkg::ST_RANGE;
                                state_next  = S_FINISH;
                            end
                        end
                        sta_pkg::ACT_CLEAR: begin
                            addr_next  = '0;
                            count_next = '0;
                            hint_next  = '0;
                            state_next = S_WIPE;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                state_next = S_FINISH;
                unique case (op_reg)
                    sta_pkg::ACT_INS_AT: begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, val_reg};
                        if (!rd_valid) begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    sta_pkg::ACT_REMOVE: begin
                        if (!rd_valid) begin
                            status_next = sta_pkg::ST_EMPTY;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b0, rd_data};
                            count_next = count_reg - CW'(1);
                            if (CW'(addr_reg) < hint_reg) begin
                                hint_next = CW'(addr_reg);
                            end
                        end
                    end
                    sta_pkg::ACT_READ: begin
                        if (!rd_valid) begin
                            status_next = sta_pkg::ST_EMPTY;
                        end else begin
                            rdval_next = 32'(rd_data);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (hit) begin
                    slot_out_next = 8'(addr_reg);
                    state_next    = S_FINISH;
                    if (op_reg == sta_pkg::ACT_INS_AUTO) begin
                        ram_we     = 1'b1;
                        ram_wdata  = {1'b1, val_reg};
                        count_next = count_reg + CW'(1);
                        hint_next  = CW'(addr_reg) + CW'(1);
                    end
                end else if (addr_reg == LAST) begin
                    status_next = (op_reg == sta_pkg::ACT_INS_AUTO) ? sta_pkg::ST_FULL
                                                                    : sta_pkg::ST_NOTFOUND;
                    state_next  = S_FINISH;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_WIPE: begin
                ram_we = 1'b1;
                if (addr_reg == LAST) begin
                    state_next = S_FINISH;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            hint_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            hint_reg  <= hint_next;
            count_reg <= count_next;
        end
        op_reg       <= op_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        rdval_reg    <= rdval_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("Used count exceeds the capacity.");

    a_hint_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg <= count_reg)
        else $error("Free hint is above the used count.");

    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_INIT || state_reg == S_LOOK ||
                    state_reg == S_SCAN || state_reg == S_WIPE))
        else $error("Memory write outside a working state.");

    a_wipe_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WIPE) |-> (count_reg == '0 && hint_reg == '0))
        else $error("Count or hint not cleared during a clear sweep.");
`endif

endmodule

[design/slot_table_allocator.sv]
// Slot table allocator top level with a result output register.
// Range errors, a full hint and unused actions go straight to the result state; read,
// insert-at and remove pass through a look-up state; insert-auto and find step through
// the slots in a scan state until a hit or the last slot; clear sweeps every slot. A new
// request is accepted only after the result of the previous one is handed on. After reset
// a sweep empties the memory while s_ready stays low.
module slot_table_allocator #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sta_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sta_pkg::out_item_t m_item
);

    logic               res_valid;
    logic               res_ready;
    sta_pkg::out_item_t res_item;
    logic               m_valid_reg;
    sta_pkg::out_item_t m_item_reg;

    sta_engine #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(s_valid),
        .req_ready(s_ready),
        .req_item (s_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item (res_item)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
